>>> rtl/slac_pkg.sv
`default_nettype none

package slac_pkg;

  // Cache geometry
  localparam int unsigned TOTAL_LINES = 512;
  localparam int unsigned LINE_BYTES  = 32;
  localparam int unsigned ADDR_WIDTH  = 32;

  localparam int unsigned IDX_W   = $clog2(TOTAL_LINES);
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
  localparam int unsigned TAG_W   = ADDR_WIDTH - OFF_W;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LW_W    = 4;
  localparam int unsigned SH_W    = $clog2(ADDR_WIDTH + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = LW_W;

  localparam logic [LW_W-1:0] LW_MAX = LW_W'(IDX_W);

  // Request codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_WAYS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_WRITE_ALC = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    line_t            data;
  } line_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } line_rd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

>>> rtl/slac_line_store.sv
`default_nettype none

// Line store: valid, tag and stamp of every line; one write, one registered read.
module slac_line_store (
  input  wire                  clk_i,
  input  slac_pkg::line_wr_t   wr_i,
  input  slac_pkg::line_rd_t   rd_i,
  output slac_pkg::line_t      rd_data_o
);

  slac_pkg::line_t mem_q [slac_pkg::TOTAL_LINES];
  slac_pkg::line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/set_assoc_lru_cache_hits_core.sv
// A load or store reads its set in the scan state; the update state writes back
// and strobes the result. The line store read port walks the ways of the set one
// per cycle; busy holds off a new request until idle. Clear invalidates every line,
// op 3 returns the hit count. Reset: a pass invalidates every line, busy stays high
// meanwhile. Results are strobed on done_o for one cycle; the receiver cannot stall.
`default_nettype none

module set_assoc_lru_cache_hits_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        op_i,
  input  wire  [slac_pkg::ADDR_WIDTH-1:0]   address_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic [slac_pkg::CNT_W-1:0]        hit_count_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [slac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [slac_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W   = slac_pkg::IDX_W;
  localparam int unsigned TAG_W   = slac_pkg::TAG_W;
  localparam int unsigned STAMP_W = slac_pkg::STAMP_W;
  localparam int unsigned CNT_W   = slac_pkg::CNT_W;
  localparam int unsigned LW_W    = slac_pkg::LW_W;
  localparam int unsigned SH_W    = slac_pkg::SH_W;

  // Configuration
  logic [LW_W-1:0] log2_ways_q;
  logic            nwa_q;

  // Sequencer and counters
  slac_pkg::state_e state_q, state_d;
  logic [STAMP_W-1:0] access_q, access_d;
  logic [CNT_W-1:0]   hits_q, hits_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic               clr_res_q, clr_res_d;

  // Request held for the walk
  logic [1:0]         op_q, op_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [IDX_W-1:0]   base_q, base_d;
  logic [IDX_W-1:0]   ways_m1_q, ways_m1_d;

  // Walk of the set
  logic [IDX_W-1:0]   iss_q, iss_d;
  logic               iss_done_q, iss_done_d;
  logic               rv_q, rv_d;
  logic [IDX_W-1:0]   rentry_q, rentry_d;
  logic               hit_found_q, hit_found_d;
  logic [IDX_W-1:0]   hit_entry_q, hit_entry_d;
  logic               inv_found_q, inv_found_d;
  logic [IDX_W-1:0]   inv_entry_q, inv_entry_d;
  logic [IDX_W-1:0]   min_entry_q, min_entry_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;

  // Result register
  logic               done_q, done_d;
  logic               hit_res_q, hit_res_d;
  logic [CNT_W-1:0]   cnt_res_q, cnt_res_d;

  // Line store ports
  slac_pkg::line_wr_t wr;
  slac_pkg::line_rd_t rd;
  slac_pkg::line_t    rd_data;

  // Address split under the current way count
  logic [LW_W-1:0]  lw;
  logic [IDX_W-1:0] set_mask;
  logic [IDX_W-1:0] set_idx;
  logic [SH_W-1:0]  tag_sh;
  logic [slac_pkg::ADDR_WIDTH-1:0] tag_full;

  // Shared compare unit
  logic tag_eq;
  logic older;
  logic last_way;

  slac_line_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_ways_q <= '0;
      nwa_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        slac_pkg::CFG_LOG2_WAYS:    log2_ways_q <= cfg_data_i;
        slac_pkg::CFG_NO_WRITE_ALC: nwa_q       <= cfg_data_i[0];
      endcase
    end
  end

  // Saturate the associativity at one fully associative set
  assign lw       = (log2_ways_q > slac_pkg::LW_MAX) ? slac_pkg::LW_MAX : log2_ways_q;
  assign set_mask = {IDX_W{1'b1}} >> lw;
  assign set_idx  = address_i[slac_pkg::OFF_W +: IDX_W] & set_mask;
  assign tag_sh   = SH_W'(slac_pkg::OFF_W + IDX_W) - SH_W'(lw);
  assign tag_full = address_i >> tag_sh;

  assign tag_eq   = rd_data.valid && (rd_data.tag == tag_q);
  assign older    = rd_data.stamp < min_stamp_q;
  assign last_way = rentry_q == (base_q | ways_m1_q);

  always_comb begin
    state_d     = state_q;
    access_d    = access_q;
    hits_d      = hits_q;
    clr_d       = clr_q;
    clr_res_d   = clr_res_q;
    op_d        = op_q;
    tag_d       = tag_q;
    base_d      = base_q;
    ways_m1_d   = ways_m1_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    rv_d        = 1'b0;
    rentry_d    = rentry_q;
    hit_found_d = hit_found_q;
    hit_entry_d = hit_entry_q;
    inv_found_d = inv_found_q;
    inv_entry_d = inv_entry_q;
    min_entry_d = min_entry_q;
    min_stamp_d = min_stamp_q;
    done_d      = 1'b0;
    hit_res_d   = hit_res_q;
    cnt_res_d   = cnt_res_q;
    wr          = '0;
    rd          = '0;
    busy        = 1'b1;

    unique case (state_q)
      slac_pkg::ST_CLEAR: begin
        // Sweep the store, one line a cycle
        wr.en   = 1'b1;
        wr.addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == {IDX_W{1'b1}}) begin
          state_d   = slac_pkg::ST_IDLE;
          done_d    = clr_res_q;
          hit_res_d = 1'b0;
          cnt_res_d = '0;
          clr_res_d = 1'b0;
        end
      end

      slac_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (op_i)
            slac_pkg::OP_CLEAR: begin
              access_d  = '0;
              hits_d    = '0;
              clr_d     = '0;
              clr_res_d = 1'b1;
              state_d   = slac_pkg::ST_CLEAR;
            end
            slac_pkg::OP_NONE: begin
              done_d    = 1'b1;
              hit_res_d = 1'b0;
              cnt_res_d = hits_q;
            end
            default: begin
              op_d        = op_i;
              tag_d       = tag_full[TAG_W-1:0];
              base_d      = set_idx << lw;
              ways_m1_d   = ~({IDX_W{1'b1}} << lw);
              iss_d       = '0;
              iss_done_d  = 1'b0;
              hit_found_d = 1'b0;
              inv_found_d = 1'b0;
              state_d     = slac_pkg::ST_SCAN;
            end
          endcase
        end
      end

      slac_pkg::ST_SCAN: begin
        // Issue one way a cycle
        if (!iss_done_q) begin
          rd.en    = 1'b1;
          rd.addr  = base_q | iss_q;
          rv_d     = 1'b1;
          rentry_d = base_q | iss_q;
          if (iss_q == ways_m1_q) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + 1'b1;
          end
        end
        // Judge the way read last cycle
        if (rv_q) begin
          if (tag_eq && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_entry_d = rentry_q;
          end
          if (!rd_data.valid && !inv_found_q) begin
            inv_found_d = 1'b1;
            inv_entry_d = rentry_q;
          end
          if (rentry_q == base_q || older) begin
            min_entry_d = rentry_q;
            min_stamp_d = rd_data.stamp;
          end
          if (last_way) begin
            state_d = slac_pkg::ST_UPDATE;
          end
        end
      end

      slac_pkg::ST_UPDATE: begin
        wr.data.valid = 1'b1;
        wr.data.tag   = tag_q;
        wr.data.stamp = access_q;
        if (hit_found_q) begin
          wr.en   = 1'b1;
          wr.addr = hit_entry_q;
        end else if (!(op_q == slac_pkg::OP_STORE && nwa_q)) begin
          wr.en   = 1'b1;
          wr.addr = inv_found_q ? inv_entry_q : min_entry_q;
        end
        if (hit_found_q && hits_q != {CNT_W{1'b1}}) begin
          hits_d = hits_q + 1'b1;
        end
        if (access_q != {STAMP_W{1'b1}}) begin
          access_d = access_q + 1'b1;
        end
        done_d    = 1'b1;
        hit_res_d = hit_found_q;
        cnt_res_d = hits_d;
        state_d   = slac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= slac_pkg::ST_CLEAR;
    end else begin
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q    <= '0;
      hits_q      <= '0;
      clr_q       <= '0;
      clr_res_q   <= 1'b0;
      iss_done_q  <= 1'b0;
      rv_q        <= 1'b0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      access_q    <= access_d;
      hits_q      <= hits_d;
      clr_q       <= clr_d;
      clr_res_q   <= clr_res_d;
      iss_done_q  <= iss_done_d;
      rv_q        <= rv_d;
      hit_found_q <= hit_found_d;
      inv_found_q <= inv_found_d;
      done_q      <= done_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    tag_q       <= tag_d;
    base_q      <= base_d;
    ways_m1_q   <= ways_m1_d;
    iss_q       <= iss_d;
    rentry_q    <= rentry_d;
    hit_entry_q <= hit_entry_d;
    inv_entry_q <= inv_entry_d;
    min_entry_q <= min_entry_d;
    min_stamp_q <= min_stamp_d;
    hit_res_q   <= hit_res_d;
    cnt_res_q   <= cnt_res_d;
  end

  assign done_o      = done_q;
  assign hit_o       = hit_res_q;
  assign hit_count_o = cnt_res_q;

endmodule

`default_nettype wire
